/* sv/mftc_pkg.sv */
// Package for the motor feedback turn counter.
// Holds shared types, codes and constants; depends on nothing.
`default_nettype none
package mftc_pkg;

  // Parameter defaults
  localparam int MOTOR_SLOTS_DEF    = 32;
  localparam int TICKS_PER_TURN_DEF = 8192;

  // Field widths
  localparam int ID_W     = 11;
  localparam int BASE_W   = 5;
  localparam int POS_W    = 16;
  localparam int TICK_W   = 32;
  localparam int SLOT_O_W = 5;
  localparam int SLOT_C_W = 13;   // signed slot arithmetic, holds -2047..2078
  localparam int CFG_A_W  = 8;
  localparam int CFG_D_W  = 11;

  // Rollover thresholds
  localparam logic [POS_W-1:0] FWD_OLD_MIN = 16'd5000;
  localparam logic [POS_W-1:0] FWD_NEW_MAX = 16'd4000;
  localparam logic [POS_W-1:0] BWD_NEW_MIN = 16'd6000;

  // Identifiers that this block does not handle
  localparam logic [ID_W-1:0] RSV_ID_A = 11'h307;
  localparam logic [ID_W-1:0] RSV_ID_B = 11'h008;
  localparam logic [ID_W-1:0] RSV_ID_C = 11'h301;
  localparam logic [ID_W-1:0] RSV_ID_D = 11'h302;
  localparam logic [ID_W-1:0] RSV_ID_E = 11'h303;

  // Register reset values
  localparam logic [ID_W-1:0]   BASE_ID_RST     = 11'd513;
  localparam logic [BASE_W-1:0] SECOND_BASE_RST = 5'd11;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_BASE_ID         = 8'd0,
    CFG_SECOND_BUS_BASE = 8'd1
  } mftc_cfg_idx_t;

  typedef enum logic {
    OP_FEEDBACK = 1'b0,
    OP_CLEAR    = 1'b1
  } mftc_op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_RESERVED = 2'd1,
    STAT_RANGE    = 2'd2
  } mftc_status_t;

  typedef enum logic {
    S_IDLE,
    S_CALC
  } mftc_state_t;

  // Decoder result
  typedef struct packed {
    mftc_status_t        status;
    logic [SLOT_C_W-1:0] slot_raw;
  } mftc_dec_t;

  // One store entry
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [TICK_W-1:0] tick;
  } mftc_entry_t;

endpackage
`default_nettype wire

/* sv/mftc_decode.sv */
// Slot mapping and frame classification for the turn counter.
// Depends on mftc_pkg.
`default_nettype none
module mftc_decode #(
  parameter int MOTOR_SLOTS = 32
) (
  input  wire logic                          op,
  input  wire logic                          bus,
  input  wire logic [mftc_pkg::ID_W-1:0]     frame_id,
  input  wire logic [mftc_pkg::ID_W-1:0]     base_id,
  input  wire logic [mftc_pkg::BASE_W-1:0]   second_bus_base,
  output mftc_pkg::mftc_dec_t                dec
);
  import mftc_pkg::*;

  logic [SLOT_C_W-1:0] slot_raw;
  logic                reserved;
  logic                in_range;

  // Form the signed slot
  assign slot_raw = SLOT_C_W'(frame_id) - SLOT_C_W'(base_id)
                  + (bus ? SLOT_C_W'(second_bus_base) : '0);

  assign reserved = (frame_id == RSV_ID_A) || (frame_id == RSV_ID_B) ||
                    (frame_id == RSV_ID_C) || (frame_id == RSV_ID_D) ||
                    (frame_id == RSV_ID_E);

  assign in_range = !slot_raw[SLOT_C_W-1] &&
                    (slot_raw[SLOT_C_W-2:0] < (SLOT_C_W-1)'(MOTOR_SLOTS));

  // Classify: reserved check first, feedback frames only
  always_comb begin
    dec.slot_raw = slot_raw;
    if (op == OP_FEEDBACK && reserved) begin
      dec.status = STAT_RESERVED;
    end else if (!in_range) begin
      dec.status = STAT_RANGE;
    end else begin
      dec.status = STAT_OK;
    end
  end

endmodule
`default_nettype wire

/* sv/mftc_store.sv */
// Per-slot store of last position and tick total, one read and one write port.
// Read data is registered; entries never written read as zero. Depends on mftc_pkg.
`default_nettype none
module mftc_store #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_W-1:0]    rd_addr,
  output mftc_pkg::mftc_entry_t     rd_data,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_W-1:0]    wr_addr,
  input  mftc_pkg::mftc_entry_t     wr_data
);
  import mftc_pkg::*;

  mftc_entry_t      mem [DEPTH];
  mftc_entry_t      rd_q_r;
  logic [DEPTH-1:0] valid_r;
  logic             rd_vld_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Track written entries; reset empties the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule
`default_nettype wire

/* sv/mftc_accum.sv */
// Tick accumulation with forward and backward encoder rollover detection.
// Depends on mftc_pkg.
`default_nettype none
module mftc_accum #(
  parameter int TICKS_PER_TURN = 8192
) (
  input  wire logic [mftc_pkg::POS_W-1:0]  old_pos,
  input  wire logic [mftc_pkg::POS_W-1:0]  new_pos,
  input  wire logic [mftc_pkg::TICK_W-1:0] old_tick,
  output logic      [mftc_pkg::TICK_W-1:0] new_tick
);
  import mftc_pkg::*;

  localparam logic [TICK_W-1:0] TPT = TICK_W'(TICKS_PER_TURN);

  logic [TICK_W-1:0] old_w;
  logic [TICK_W-1:0] new_w;
  logic              fwd_wrap;
  logic              bwd_wrap;

  assign old_w    = TICK_W'(old_pos);
  assign new_w    = TICK_W'(new_pos);
  assign fwd_wrap = (old_pos > FWD_OLD_MIN) && (new_pos < FWD_NEW_MAX);
  assign bwd_wrap = (old_pos < FWD_OLD_MIN) && (new_pos > BWD_NEW_MIN);

  // Add the step, corrected by one turn on a wrap
  always_comb begin
    if (fwd_wrap) begin
      new_tick = old_tick + (TPT - old_w) + new_w;
    end else if (bwd_wrap) begin
      new_tick = old_tick - ((TPT - new_w) + old_w);
    end else begin
      new_tick = old_tick + (new_w - old_w);
    end
  end

endmodule
`default_nettype wire

/* sv/motor_feedback_turn_counter.sv */
// Motor feedback turn counter: each item takes a read of the slot store, then the
// update and write-back, and no new item is taken until the update is done. The
// result is registered once the output register is free, and waits there while
// the next item is taken. Synchronous active-low reset restores the registers to
// their defaults and marks every store entry as zero at once; both ready outputs
// stay low during reset and the block accepts items as soon as reset is released.
// Depends on mftc_pkg, mftc_decode, mftc_store and mftc_accum.
`default_nettype none
module motor_feedback_turn_counter #(
  parameter int MOTOR_SLOTS    = mftc_pkg::MOTOR_SLOTS_DEF,
  parameter int TICKS_PER_TURN = mftc_pkg::TICKS_PER_TURN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: frame_id[10:0], byte0[18:11], byte1[26:19], byte2[34:27], byte3[42:35],
  //        byte4[50:43], byte5[58:51], byte6[66:59], zero[71:67]
  input  wire logic [71:0] in_tdata,
  // tuser: op[0], bus[1]
  input  wire logic [1:0]  in_tuser,
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: slot[4:0], position[20:5], speed[36:21], current[52:37],
  //        temperature[60:53], turn_count[92:61], zero[95:93]
  output logic [95:0]      out_tdata,
  // tuser: status[1:0]
  output logic [1:0]       out_tuser,
  // Configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [mftc_pkg::CFG_A_W-1:0] cfg_addr,
  input  wire logic [mftc_pkg::CFG_D_W-1:0] cfg_data
);
  import mftc_pkg::*;

  localparam int SLOT_W = $clog2(MOTOR_SLOTS);

  mftc_state_t         state_r, state_nxt;
  logic [ID_W-1:0]     base_id_r;
  logic [BASE_W-1:0]   second_base_r;

  // Held item
  logic                op_r;
  mftc_dec_t           dec_r;
  logic [POS_W-1:0]    pos_r;
  logic [15:0]         speed_r;
  logic [15:0]         current_r;
  logic [7:0]          temp_r;

  // Output register
  logic                out_valid_r;
  mftc_status_t        o_status_r;
  logic [SLOT_O_W-1:0] o_slot_r;
  logic [POS_W-1:0]    o_pos_r;
  logic [15:0]         o_speed_r;
  logic [15:0]         o_current_r;
  logic [7:0]          o_temp_r;
  logic [TICK_W-1:0]   o_turn_r;

  mftc_dec_t           dec;
  mftc_entry_t         rd_data;
  mftc_entry_t         wr_data;
  logic [TICK_W-1:0]   new_tick;
  logic                in_acc;
  logic                out_free;
  logic                rd_en;
  logic                wr_en;
  logic                load_out;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Configuration registers
  assign cfg_ready = rst_n;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_id_r     <= BASE_ID_RST;
      second_base_r <= SECOND_BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        CFG_BASE_ID:         base_id_r     <= cfg_data;
        CFG_SECOND_BUS_BASE: second_base_r <= cfg_data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  mftc_decode #(
    .MOTOR_SLOTS(MOTOR_SLOTS)
  ) u_decode (
    .op              (in_tuser[0]),
    .bus             (in_tuser[1]),
    .frame_id        (in_tdata[10:0]),
    .base_id         (base_id_r),
    .second_bus_base (second_base_r),
    .dec             (dec)
  );

  mftc_store #(
    .DEPTH (MOTOR_SLOTS),
    .ADDR_W(SLOT_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (dec.slot_raw[SLOT_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (dec_r.slot_raw[SLOT_W-1:0]),
    .wr_data (wr_data)
  );

  mftc_accum #(
    .TICKS_PER_TURN(TICKS_PER_TURN)
  ) u_accum (
    .old_pos  (rd_data.pos),
    .new_pos  (pos_r),
    .old_tick (rd_data.tick),
    .new_tick (new_tick)
  );

  // Clear keeps the position and zeroes the count
  always_comb begin
    if (op_r == OP_CLEAR) begin
      wr_data.pos  = rd_data.pos;
      wr_data.tick = '0;
    end else begin
      wr_data.pos  = pos_r;
      wr_data.tick = new_tick;
    end
  end

  // Sequencer: read on accept, update and write back once the result register is free
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          rd_en     = (dec.status == STAT_OK);
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (out_free) begin
          wr_en     = (dec_r.status == STAT_OK);
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the accepted item; payload words are sent high byte first
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r      <= in_tuser[0];
      dec_r     <= dec;
      pos_r     <= {in_tdata[18:11], in_tdata[26:19]};
      speed_r   <= {in_tdata[34:27], in_tdata[42:35]};
      current_r <= {in_tdata[50:43], in_tdata[58:51]};
      temp_r    <= in_tdata[66:59];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_status_r  <= dec_r.status;
      o_slot_r    <= (dec_r.status == STAT_OK) ? dec_r.slot_raw[SLOT_O_W-1:0] : '0;
      o_pos_r     <= pos_r;
      o_speed_r   <= speed_r;
      o_current_r <= current_r;
      o_temp_r    <= temp_r;
      o_turn_r    <= (dec_r.status == STAT_OK && op_r == OP_FEEDBACK) ? new_tick : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_status_r;
  assign out_tdata  = {3'b000, o_turn_r, o_temp_r, o_current_r, o_speed_r,
                       o_pos_r, o_slot_r};

  // Checks
  a_acc_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_CALC)
    else $error("accepted item did not enter update");

  a_wr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_CALC) && (dec_r.status == STAT_OK))
    else $error("store written for an item that must change nothing");

  a_calc_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CALC) && !out_free |=> state_r == S_CALC)
    else $error("update left while result register was full");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("loaded result not presented");

endmodule
`default_nettype wire
